FILE: sv/prd_pkg.sv
`default_nettype none
package prd_pkg;

    localparam int TICK_W = 24;
    localparam int PID_W  = 4;

    typedef enum logic [2:0] {
        ST_LOADED   = 3'd0,
        ST_SLICE    = 3'd1,
        ST_ALL_DONE = 3'd2,
        ST_FULL     = 3'd3,
        ST_REJECTED = 3'd4
    } status_t;

    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
        logic [15:0] remain;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

FILE: sv/prd_ram.sv
`default_nettype none
module prd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: sv/priority_round_robin_dispatcher.sv
// A load's result appears in the cycle after start, and busy stays low.
// A dispatch scans the table one entry at a time (S_RD, S_EVAL), then rereads the head
// (S_HEAD_RD, S_HEAD); if the queue is idle, time jumps to the next arrival and it rescans.
// Results are strobed for exactly one cycle on result_valid; the receiver cannot stall.
// Reset (rst_n low, asynchronous) empties the table and sets the quantum to 4.
`default_nettype none
module priority_round_robin_dispatcher #(
    parameter int MAX_PROCESSES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        action,
    input  wire logic [15:0] arrival_tick,
    input  wire logic [15:0] burst_ticks,
    input  wire logic [7:0]  priority_level,
    output logic             result_valid,
    output logic [2:0]       status,
    output logic [3:0]       process_id,
    output logic [23:0]      slice_start,
    output logic [23:0]      slice_end,
    output logic             finished,
    output logic [23:0]      turnaround,
    output logic [23:0]      waiting
);

    localparam int IDW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CW  = $clog2(MAX_PROCESSES + 1);
    localparam int TW  = prd_pkg::TICK_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EVAL,
        S_HEAD_RD,
        S_HEAD
    } state_t;

    state_t                   state_reg, state_next;
    logic [15:0]              quantum_reg, quantum_next;
    logic [MAX_PROCESSES-1:0] adm_reg, adm_next;
    logic [MAX_PROCESSES-1:0] fin_reg, fin_next;
    logic [CW-1:0]            pcount_reg, pcount_next;
    logic [CW-1:0]            fcount_reg, fcount_next;
    logic [CW-1:0]            rcount_reg, rcount_next;
    logic [TW-1:0]            tick_reg, tick_next;
    logic                     preempt_reg, preempt_next;
    logic                     started_reg, started_next;
    logic [IDW-1:0]           last_reg, last_next;
    logic [IDW-1:0]           idx_reg, idx_next;
    logic [IDW-1:0]           head_reg, head_next;
    logic                     bv_reg, bv_next;
    logic [IDW-1:0]           bid_reg, bid_next;
    logic [23:0]              bkey_reg, bkey_next;
    logic                     xv_reg, xv_next;
    logic [IDW-1:0]           xid_reg, xid_next;
    logic [23:0]              xkey_reg, xkey_next;
    logic                     ev_reg, ev_next;
    logic [15:0]              early_reg, early_next;

    logic                     rv_reg, rv_next;
    prd_pkg::status_t         st_reg, st_next;
    logic [3:0]               pid_reg, pid_next;
    logic [TW-1:0]            sstart_reg, sstart_next;
    logic [TW-1:0]            send_reg, send_next;
    logic                     fin_out_reg, fin_out_next;
    logic [TW-1:0]            turn_reg, turn_next;
    logic [TW-1:0]            wait_reg, wait_next;

    logic                     we;
    logic [IDW-1:0]           waddr;
    prd_pkg::entry_t          wentry;
    logic [IDW-1:0]           raddr;
    logic [prd_pkg::ENTRY_W-1:0] rdata;
    prd_pkg::entry_t          rentry;

    logic                     accept;
    logic                     adm_i, na, cand, last_pass;
    logic [23:0]              key;
    logic [CW-1:0]            cnt_now;
    logic [15:0]              q;
    logic [15:0]              run;
    logic [TW-1:0]            tick_new, turn_val;

    assign accept = start && !busy;
    assign rentry = prd_pkg::entry_t'(rdata);
    assign raddr  = (state_reg == S_HEAD_RD) ? head_reg : idx_reg;

    prd_ram #(
        .WIDTH(prd_pkg::ENTRY_W),
        .DEPTH(1 << IDW)
    ) u_table (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wentry),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        quantum_next = cfg_we ? cfg_wdata : quantum_reg;
        adm_next     = adm_reg;
        fin_next     = fin_reg;
        pcount_next  = pcount_reg;
        fcount_next  = fcount_reg;
        rcount_next  = rcount_reg;
        tick_next    = tick_reg;
        preempt_next = preempt_reg;
        started_next = started_reg;
        last_next    = last_reg;
        idx_next     = idx_reg;
        head_next    = head_reg;
        bv_next      = bv_reg;
        bid_next     = bid_reg;
        bkey_next    = bkey_reg;
        xv_next      = xv_reg;
        xid_next     = xid_reg;
        xkey_next    = xkey_reg;
        ev_next      = ev_reg;
        early_next   = early_reg;
        rv_next      = 1'b0;
        st_next      = st_reg;
        pid_next     = pid_reg;
        sstart_next  = sstart_reg;
        send_next    = send_reg;
        fin_out_next = fin_out_reg;
        turn_next    = turn_reg;
        wait_next    = wait_reg;
        we           = 1'b0;
        waddr        = pcount_reg[IDW-1:0];
        wentry       = '{arrival: arrival_tick, burst: burst_ticks,
                         prio: priority_level, remain: burst_ticks};

        adm_i     = adm_reg[idx_reg];
        na        = !adm_i && ({8'b0, rentry.arrival} <= tick_reg);
        cand      = (adm_i && !fin_reg[idx_reg]) || na;
        key       = {rentry.prio, rentry.arrival};
        cnt_now   = rcount_reg + CW'(na);
        last_pass = (CW'(idx_reg) + CW'(1)) == pcount_reg;

        q         = (quantum_reg == 16'd0) ? 16'd1 : quantum_reg;
        run       = (rentry.remain > q) ? q : rentry.remain;
        tick_new  = tick_reg + {8'b0, run};
        turn_val  = tick_new - {8'b0, rentry.arrival};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rv_next      = 1'b1;
                    pid_next     = '0;
                    sstart_next  = '0;
                    send_next    = '0;
                    fin_out_next = 1'b0;
                    turn_next    = '0;
                    wait_next    = '0;
                    if (!action)
                    begin
                        if (started_reg)
                        begin
                            st_next = prd_pkg::ST_REJECTED;
                        end
                        else if (pcount_reg >= CW'(MAX_PROCESSES))
                        begin
                            st_next = prd_pkg::ST_FULL;
                        end
                        else
                        begin
                            st_next = prd_pkg::ST_LOADED;
                            pid_next = 4'(pcount_reg[IDW-1:0]);
                            we = 1'b1;
                            adm_next[pcount_reg[IDW-1:0]] = 1'b0;
                            fin_next[pcount_reg[IDW-1:0]] = 1'b0;
                            pcount_next = pcount_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        started_next = 1'b1;
                        if (fcount_reg >= pcount_reg)
                        begin
                            st_next = prd_pkg::ST_ALL_DONE;
                        end
                        else
                        begin
                            rv_next    = 1'b0;
                            idx_next   = '0;
                            bv_next    = 1'b0;
                            xv_next    = 1'b0;
                            ev_next    = 1'b0;
                            state_next = S_RD;
                        end
                    end
                end
            end
            S_RD:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (na)
                begin
                    adm_next[idx_reg] = 1'b1;
                    rcount_next = cnt_now;
                end
                if (cand && (!bv_reg || key < bkey_reg))
                begin
                    bv_next   = 1'b1;
                    bid_next  = idx_reg;
                    bkey_next = key;
                end
                if (cand && idx_reg != last_reg && (!xv_reg || key < xkey_reg))
                begin
                    xv_next   = 1'b1;
                    xid_next  = idx_reg;
                    xkey_next = key;
                end
                if (!adm_i && !na && (!ev_reg || rentry.arrival < early_reg))
                begin
                    ev_next    = 1'b1;
                    early_next = rentry.arrival;
                end
                state_next = S_RD;
                idx_next   = idx_reg + IDW'(1);
                if (last_pass)
                begin
                    idx_next = '0;
                    if (cnt_now == '0)
                    begin
                        bv_next = 1'b0;
                        xv_next = 1'b0;
                        ev_next = 1'b0;
                        if (ev_reg || (!adm_i && !na))
                        begin
                            tick_next = (!adm_i && !na && (!ev_reg || rentry.arrival < early_reg))
                                ? {8'b0, rentry.arrival} : {8'b0, early_reg};
                        end
                        else
                        begin
                            rv_next      = 1'b1;
                            st_next      = prd_pkg::ST_ALL_DONE;
                            pid_next     = '0;
                            sstart_next  = '0;
                            send_next    = '0;
                            fin_out_next = 1'b0;
                            turn_next    = '0;
                            wait_next    = '0;
                            state_next   = S_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = S_HEAD_RD;
                        if (preempt_reg && cnt_now > CW'(1))
                        begin
                            head_next = xv_next ? xid_next : bid_next;
                        end
                        else
                        begin
                            head_next = bv_next ? bid_next : xid_next;
                        end
                    end
                end
            end
            S_HEAD_RD:
            begin
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                state_next   = S_IDLE;
                rv_next      = 1'b1;
                st_next      = prd_pkg::ST_SLICE;
                pid_next     = 4'(head_reg);
                sstart_next  = tick_reg;
                send_next    = tick_new;
                tick_next    = tick_new;
                we           = 1'b1;
                waddr        = head_reg;
                wentry       = rentry;
                wentry.remain = rentry.remain - run;
                if (rentry.remain > q)
                begin
                    preempt_next = 1'b1;
                    last_next    = head_reg;
                    fin_out_next = 1'b0;
                    turn_next    = '0;
                    wait_next    = '0;
                end
                else
                begin
                    preempt_next = 1'b0;
                    fin_out_next = 1'b1;
                    turn_next    = turn_val;
                    wait_next    = turn_val - {8'b0, rentry.burst};
                    fin_next[head_reg] = 1'b1;
                    rcount_next  = rcount_reg - CW'(1);
                    fcount_next  = fcount_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            quantum_reg <= 16'd4;
            adm_reg     <= '0;
            fin_reg     <= '0;
            pcount_reg  <= '0;
            fcount_reg  <= '0;
            rcount_reg  <= '0;
            tick_reg    <= '0;
            preempt_reg <= 1'b0;
            started_reg <= 1'b0;
            last_reg    <= '0;
            rv_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            quantum_reg <= quantum_next;
            adm_reg     <= adm_next;
            fin_reg     <= fin_next;
            pcount_reg  <= pcount_next;
            fcount_reg  <= fcount_next;
            rcount_reg  <= rcount_next;
            tick_reg    <= tick_next;
            preempt_reg <= preempt_next;
            started_reg <= started_next;
            last_reg    <= last_next;
            rv_reg      <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        head_reg    <= head_next;
        bv_reg      <= bv_next;
        bid_reg     <= bid_next;
        bkey_reg    <= bkey_next;
        xv_reg      <= xv_next;
        xid_reg     <= xid_next;
        xkey_reg    <= xkey_next;
        ev_reg      <= ev_next;
        early_reg   <= early_next;
        st_reg      <= st_next;
        pid_reg     <= pid_next;
        sstart_reg  <= sstart_next;
        send_reg    <= send_next;
        fin_out_reg <= fin_out_next;
        turn_reg    <= turn_next;
        wait_reg    <= wait_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = rv_reg;
    assign status       = st_reg;
    assign process_id   = pid_reg;
    assign slice_start  = sstart_reg;
    assign slice_end    = send_reg;
    assign finished     = fin_out_reg;
    assign turnaround   = turn_reg;
    assign waiting      = wait_reg;

endmodule
`default_nettype wire
